### design/mdvc_pkg.sv
// Package for the mode-digit virtual processor: memory size, sequencer states,
// status codes, opcodes and addressing modes. No dependencies.
`default_nettype none
package mdvc_pkg;

   localparam int MEM_WORDS = 4096;
   localparam int ADDR_BITS = $clog2(MEM_WORDS);

   // x / 100 == (x * RECIP_100) >> 24 for every x below 100000
   localparam logic [31:0] RECIP_100 = 32'd167773;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_FETCH, ST_WORD, ST_MOD, ST_DIG1, ST_DIG2,
      ST_OPA, ST_OPB, ST_OPC, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3,
      ST_WB, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      STATUS_RUN  = 2'd0,
      STATUS_WAIT = 2'd1,
      STATUS_HALT = 2'd2,
      STATUS_ERR  = 2'd3
   } status_type;

   localparam logic [6:0] OP_ADD  = 7'd1;
   localparam logic [6:0] OP_MUL  = 7'd2;
   localparam logic [6:0] OP_IN   = 7'd3;
   localparam logic [6:0] OP_OUT  = 7'd4;
   localparam logic [6:0] OP_JT   = 7'd5;
   localparam logic [6:0] OP_JF   = 7'd6;
   localparam logic [6:0] OP_LT   = 7'd7;
   localparam logic [6:0] OP_EQ   = 7'd8;
   localparam logic [6:0] OP_ARB  = 7'd9;
   localparam logic [6:0] OP_HALT = 7'd99;

   localparam logic [3:0] MODE_POS = 4'd0;
   localparam logic [3:0] MODE_IMM = 4'd1;
   localparam logic [3:0] MODE_REL = 4'd2;

endpackage
`default_nettype wire

### design/mdvc_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Used for digit decoding and for the partial products of the 64-bit multiply.
`default_nettype none
module mdvc_mul (
   input  wire logic        clock,
   input  wire logic [31:0] mul_a,
   input  wire logic [31:0] mul_b,
   output logic      [63:0] mul_p
);

   logic [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

   assign mul_p = prod_ff;

endmodule
`default_nettype wire

### design/mode_digit_virtual_cpu.sv
// Step item: fetch, serial modulo 100000 of the instruction word for the mode digits,
// digit decode, operand reads through the single memory read port, and partial
// products for multiply.
// One item at a time; req_stall is high while an item is in work.
// Reset (synchronous) starts a clearing pass over all 4096 words that zeroes memory.
`default_nettype none
module mode_digit_virtual_cpu (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd,
   input  wire logic [11:0] req_load_addr,
   input  wire logic [63:0] req_load_word,
   input  wire logic [63:0] req_input_value,
   input  wire logic        req_input_valid,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic             rsp_output_valid,
   output logic [63:0]      rsp_output_value,
   output logic             rsp_input_taken,
   output logic [11:0]      rsp_next_pc
);

   localparam int AB = mdvc_pkg::ADDR_BITS;

   mdvc_pkg::state_type state_ff, state_in;

   logic [AB-1:0]  clr_ff, clr_in;
   logic [AB-1:0]  pc_ff, pc_in;
   logic [63:0]    base_ff, base_in;
   logic           halt_ff, halt_in, err_ff, err_in;
   logic [63:0]    ival_ff, ival_in;
   logic           ivalid_ff, ivalid_in;
   logic [63:0]    sh_ff, sh_in;
   logic [16:0]    r_ff, r_in;
   logic [3:0]     cnt_ff, cnt_in;
   logic [6:0]     op_ff, op_in;
   logic [3:0]     ma_ff, ma_in, mb_ff, mb_in, mc_ff, mc_in;
   logic [1:0]     k_ff, k_in;
   logic [63:0]    a_ff, a_in, b_ff, b_in;
   logic [AB-1:0]  wa_ff, wa_in;
   logic [63:0]    acc_ff, acc_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic           res_ovalid_ff, res_ovalid_in, res_taken_ff, res_taken_in;
   logic [63:0]    res_oval_ff, res_oval_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic           rsp_ovalid_ff, rsp_ovalid_in, rsp_taken_ff, rsp_taken_in;
   logic [63:0]    rsp_oval_ff, rsp_oval_in;
   logic [11:0]    rsp_pc_ff, rsp_pc_in;

   // word memory, one write port and one read port
   logic [63:0]    mem [mdvc_pkg::MEM_WORDS];
   logic [63:0]    rdata_ff;
   logic           mem_we;
   logic [AB-1:0]  mem_wa, mem_ra;
   logic [63:0]    mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[mem_ra];
   end

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   mdvc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   // handshake
   logic accept, rsp_xfer, done_go;
   assign req_stall = (state_ff != mdvc_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign done_go   = (state_ff == mdvc_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // serial reduction step: r = (r*16 + nibble) mod 100000
   logic [20:0] red_t, red_r;
   logic [3:0]  red_sel;
   always_comb begin
      red_t   = {r_ff, sh_ff[63:60]};
      red_sel = 4'd0;
      for (int i = 1; i < 16; i++) begin
         if (red_t >= 21'(i * 100000)) begin
            red_sel = 4'(i);
         end
      end
      red_r = red_t - 21'(red_sel) * 21'd100000;
   end

   // decimal digits from the registered reciprocal product
   logic [9:0]  dq;
   logic [17:0] dq205;
   logic [6:0]  dq1, dop;
   logic [14:0] dq1x;
   logic [3:0]  dq2, dma, dmb;
   logic        dig_known;
   always_comb begin
      dq    = mul_p[33:24];
      dop   = 7'(r_ff - 17'(dq) * 17'd100);
      dq205 = 18'(dq) * 18'd205;
      dq1   = dq205[17:11];
      dma   = 4'(dq - 10'(dq1) * 10'd10);
      dq1x  = 15'(dq1) * 15'd205;
      dq2   = dq1x[14:11];
      dmb   = 4'(dq1 - 7'(dq2) * 7'd10);
      dig_known = (dop inside {[mdvc_pkg::OP_ADD:mdvc_pkg::OP_ARB]});
   end

   // operand step decode
   logic [AB:0]  pc_k;
   logic         pc_k_oob;
   logic [3:0]   mode_k;
   logic         is_write_k, last_k, tgt_oob;
   logic [63:0]  tgt;
   mdvc_pkg::state_type adv_state;
   always_comb begin
      pc_k     = {1'b0, pc_ff} + (AB+1)'(k_ff);
      pc_k_oob = pc_k >= (AB+1)'(mdvc_pkg::MEM_WORDS);
      case (k_ff)
         2'd1:    mode_k = ma_ff;
         2'd2:    mode_k = mb_ff;
         default: mode_k = mc_ff;
      endcase
      is_write_k = (k_ff == 2'd3) || (op_ff == mdvc_pkg::OP_IN);
      case (op_ff)
         mdvc_pkg::OP_ADD, mdvc_pkg::OP_MUL, mdvc_pkg::OP_LT, mdvc_pkg::OP_EQ:
            last_k = (k_ff == 2'd3);
         mdvc_pkg::OP_JT, mdvc_pkg::OP_JF:
            last_k = (k_ff == 2'd2);
         default:
            last_k = 1'b1;
      endcase
      tgt     = (mode_k == mdvc_pkg::MODE_REL) ? rdata_ff + base_ff : rdata_ff;
      tgt_oob = tgt >= 64'(mdvc_pkg::MEM_WORDS);
      if (!last_k) begin
         adv_state = mdvc_pkg::ST_OPA;
      end else if (op_ff == mdvc_pkg::OP_MUL) begin
         adv_state = mdvc_pkg::ST_MUL0;
      end else begin
         adv_state = mdvc_pkg::ST_WB;
      end
   end

   // execute
   logic [63:0] npc, wv;
   logic        npc_oob, wb_mem;
   always_comb begin
      case (op_ff)
         mdvc_pkg::OP_ADD, mdvc_pkg::OP_MUL, mdvc_pkg::OP_LT, mdvc_pkg::OP_EQ:
            npc = 64'(pc_ff) + 64'd4;
         mdvc_pkg::OP_JT:
            npc = (a_ff != 64'd0) ? b_ff : 64'(pc_ff) + 64'd3;
         mdvc_pkg::OP_JF:
            npc = (a_ff == 64'd0) ? b_ff : 64'(pc_ff) + 64'd3;
         default:
            npc = 64'(pc_ff) + 64'd2;
      endcase
      npc_oob = npc >= 64'(mdvc_pkg::MEM_WORDS);
      case (op_ff)
         mdvc_pkg::OP_ADD: wv = a_ff + b_ff;
         mdvc_pkg::OP_MUL: wv = acc_ff;
         mdvc_pkg::OP_LT:  wv = ($signed(a_ff) < $signed(b_ff)) ? 64'd1 : 64'd0;
         mdvc_pkg::OP_EQ:  wv = (a_ff == b_ff) ? 64'd1 : 64'd0;
         mdvc_pkg::OP_IN:  wv = ival_ff;
         default:          wv = base_ff + a_ff;
      endcase
      wb_mem = (op_ff inside {mdvc_pkg::OP_ADD, mdvc_pkg::OP_MUL, mdvc_pkg::OP_IN,
                              mdvc_pkg::OP_LT, mdvc_pkg::OP_EQ});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mdvc_pkg::ST_CLEAR:
            if (clr_ff == AB'(mdvc_pkg::MEM_WORDS - 1)) state_in = mdvc_pkg::ST_IDLE;
         mdvc_pkg::ST_IDLE:
            if (accept) begin
               if (!req_cmd || err_ff || halt_ff) state_in = mdvc_pkg::ST_DONE;
               else                               state_in = mdvc_pkg::ST_FETCH;
            end
         mdvc_pkg::ST_FETCH: state_in = mdvc_pkg::ST_WORD;
         mdvc_pkg::ST_WORD:
            state_in = rdata_ff[63] ? mdvc_pkg::ST_DONE : mdvc_pkg::ST_MOD;
         mdvc_pkg::ST_MOD:
            if (cnt_ff == 4'd15) state_in = mdvc_pkg::ST_DIG1;
         mdvc_pkg::ST_DIG1: state_in = mdvc_pkg::ST_DIG2;
         mdvc_pkg::ST_DIG2:
            if (!dig_known || (dop == mdvc_pkg::OP_IN && !ivalid_ff)) begin
               state_in = mdvc_pkg::ST_DONE;
            end else begin
               state_in = mdvc_pkg::ST_OPA;
            end
         mdvc_pkg::ST_OPA:
            state_in = pc_k_oob ? mdvc_pkg::ST_DONE : mdvc_pkg::ST_OPB;
         mdvc_pkg::ST_OPB:
            if (is_write_k || mode_k == mdvc_pkg::MODE_POS || mode_k == mdvc_pkg::MODE_REL) begin
               if (tgt_oob)         state_in = mdvc_pkg::ST_DONE;
               else if (is_write_k) state_in = adv_state;
               else                 state_in = mdvc_pkg::ST_OPC;
            end else begin
               state_in = adv_state;
            end
         mdvc_pkg::ST_OPC:  state_in = adv_state;
         mdvc_pkg::ST_MUL0: state_in = mdvc_pkg::ST_MUL1;
         mdvc_pkg::ST_MUL1: state_in = mdvc_pkg::ST_MUL2;
         mdvc_pkg::ST_MUL2: state_in = mdvc_pkg::ST_MUL3;
         mdvc_pkg::ST_MUL3: state_in = mdvc_pkg::ST_WB;
         mdvc_pkg::ST_WB:   state_in = mdvc_pkg::ST_DONE;
         mdvc_pkg::ST_DONE:
            if (done_go) state_in = mdvc_pkg::ST_IDLE;
         default: state_in = mdvc_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      clr_in = clr_ff;        pc_in = pc_ff;          base_in = base_ff;
      halt_in = halt_ff;      err_in = err_ff;        ival_in = ival_ff;
      ivalid_in = ivalid_ff;  sh_in = sh_ff;          r_in = r_ff;
      cnt_in = cnt_ff;        op_in = op_ff;          ma_in = ma_ff;
      mb_in = mb_ff;          mc_in = mc_ff;          k_in = k_ff;
      a_in = a_ff;            b_in = b_ff;            wa_in = wa_ff;
      acc_in = acc_ff;
      res_status_in = res_status_ff;  res_ovalid_in = res_ovalid_ff;
      res_oval_in = res_oval_ff;      res_taken_in = res_taken_ff;
      mem_we = 1'b0;  mem_wa = clr_ff;  mem_wd = 64'd0;  mem_ra = pc_ff;
      mul_a = 32'd0;  mul_b = 32'd0;

      case (state_ff)
         mdvc_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + AB'(1);
         end
         mdvc_pkg::ST_IDLE: begin
            ival_in       = req_input_value;
            ivalid_in     = req_input_valid;
            res_ovalid_in = 1'b0;
            res_oval_in   = 64'd0;
            res_taken_in  = 1'b0;
            if (err_ff)       res_status_in = mdvc_pkg::STATUS_ERR;
            else if (halt_ff) res_status_in = mdvc_pkg::STATUS_HALT;
            else              res_status_in = mdvc_pkg::STATUS_RUN;
            mem_we = accept && !req_cmd &&
                     (32'(req_load_addr) < 32'(mdvc_pkg::MEM_WORDS));
            mem_wa = AB'(req_load_addr);
            mem_wd = req_load_word;
         end
         mdvc_pkg::ST_WORD: begin
            sh_in  = rdata_ff;
            r_in   = 17'd0;
            cnt_in = 4'd0;
            // negative words never hold a valid opcode
            if (rdata_ff[63]) begin
               err_in = 1'b1;
               res_status_in = mdvc_pkg::STATUS_ERR;
            end
         end
         mdvc_pkg::ST_MOD: begin
            r_in   = red_r[16:0];
            sh_in  = {sh_ff[59:0], 4'd0};
            cnt_in = cnt_ff + 4'd1;
         end
         mdvc_pkg::ST_DIG1: begin
            mul_a = 32'(r_ff);
            mul_b = mdvc_pkg::RECIP_100;
         end
         mdvc_pkg::ST_DIG2: begin
            op_in = dop;  ma_in = dma;  mb_in = dmb;  mc_in = dq2;
            k_in  = 2'd1;
            if (dop == mdvc_pkg::OP_HALT) begin
               halt_in = 1'b1;
               res_status_in = mdvc_pkg::STATUS_HALT;
            end else if (!dig_known) begin
               err_in = 1'b1;
               res_status_in = mdvc_pkg::STATUS_ERR;
            end else if (dop == mdvc_pkg::OP_IN && !ivalid_ff) begin
               res_status_in = mdvc_pkg::STATUS_WAIT;
            end
         end
         mdvc_pkg::ST_OPA: begin
            mem_ra = pc_k[AB-1:0];
            if (pc_k_oob) begin
               err_in = 1'b1;
               res_status_in = mdvc_pkg::STATUS_ERR;
            end
         end
         mdvc_pkg::ST_OPB: begin
            mem_ra = tgt[AB-1:0];
            if (is_write_k || mode_k == mdvc_pkg::MODE_POS || mode_k == mdvc_pkg::MODE_REL) begin
               if (tgt_oob) begin
                  err_in = 1'b1;
                  res_status_in = mdvc_pkg::STATUS_ERR;
               end else if (is_write_k) begin
                  wa_in = tgt[AB-1:0];
               end
            end else begin
               // immediate passes the raw word; unknown modes read all ones
               if (k_ff == 2'd1) a_in = (mode_k == mdvc_pkg::MODE_IMM) ? rdata_ff : '1;
               else              b_in = (mode_k == mdvc_pkg::MODE_IMM) ? rdata_ff : '1;
            end
            if (!is_write_k && (mode_k == mdvc_pkg::MODE_POS || mode_k == mdvc_pkg::MODE_REL)) begin
               k_in = k_ff;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         mdvc_pkg::ST_OPC: begin
            if (k_ff == 2'd1) a_in = rdata_ff;
            else              b_in = rdata_ff;
            k_in = k_ff + 2'd1;
         end
         mdvc_pkg::ST_MUL0: begin
            mul_a = a_ff[31:0];   mul_b = b_ff[31:0];
         end
         mdvc_pkg::ST_MUL1: begin
            mul_a = a_ff[63:32];  mul_b = b_ff[31:0];
            acc_in = mul_p;
         end
         mdvc_pkg::ST_MUL2: begin
            mul_a = a_ff[31:0];   mul_b = b_ff[63:32];
            acc_in = {acc_ff[63:32] + mul_p[31:0], acc_ff[31:0]};
         end
         mdvc_pkg::ST_MUL3: begin
            acc_in = {acc_ff[63:32] + mul_p[31:0], acc_ff[31:0]};
         end
         mdvc_pkg::ST_WB: begin
            mem_wa = wa_ff;
            mem_wd = wv;
            if (npc_oob) begin
               err_in = 1'b1;
               res_status_in = mdvc_pkg::STATUS_ERR;
            end else begin
               mem_we = wb_mem;
               pc_in  = npc[AB-1:0];
               if (op_ff == mdvc_pkg::OP_ARB) base_in = wv;
               res_status_in = mdvc_pkg::STATUS_RUN;
               res_taken_in  = (op_ff == mdvc_pkg::OP_IN);
               res_ovalid_in = (op_ff == mdvc_pkg::OP_OUT);
               res_oval_in   = (op_ff == mdvc_pkg::OP_OUT) ? a_ff : 64'd0;
            end
         end
         default: begin
         end
      endcase

      // result register: load on leaving DONE, drop on transfer
      rsp_status_in = rsp_status_ff;  rsp_ovalid_in = rsp_ovalid_ff;
      rsp_oval_in   = rsp_oval_ff;    rsp_taken_in  = rsp_taken_ff;
      rsp_pc_in     = rsp_pc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_xfer;
      if (done_go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_ovalid_in = res_ovalid_ff;
         rsp_oval_in   = res_oval_ff;
         rsp_taken_in  = res_taken_ff;
         rsp_pc_in     = 12'(pc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mdvc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         base_ff      <= 64'd0;
         halt_ff      <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         base_ff      <= base_in;
         halt_ff      <= halt_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ival_ff <= ival_in;   ivalid_ff <= ivalid_in;  sh_ff <= sh_in;
      r_ff <= r_in;         cnt_ff <= cnt_in;        op_ff <= op_in;
      ma_ff <= ma_in;       mb_ff <= mb_in;          mc_ff <= mc_in;
      k_ff <= k_in;         a_ff <= a_in;            b_ff <= b_in;
      wa_ff <= wa_in;       acc_ff <= acc_in;
      res_status_ff <= res_status_in;  res_ovalid_ff <= res_ovalid_in;
      res_oval_ff <= res_oval_in;      res_taken_ff <= res_taken_in;
      rsp_status_ff <= rsp_status_in;  rsp_ovalid_ff <= rsp_ovalid_in;
      rsp_oval_ff <= rsp_oval_in;      rsp_taken_ff <= rsp_taken_in;
      rsp_pc_ff <= rsp_pc_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_output_valid = rsp_ovalid_ff;
   assign rsp_output_value = rsp_oval_ff;
   assign rsp_input_taken  = rsp_taken_ff;
   assign rsp_next_pc      = rsp_pc_ff;

endmodule
`default_nettype wire

### design/mdvc_checker.sv
// Port-level checks for the mode-digit virtual processor, bound to the top level.
// Depends on mdvc_pkg for status codes.
`default_nettype none
module mdvc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_cmd,
   input wire logic [11:0] req_load_addr,
   input wire logic [63:0] req_load_word,
   input wire logic [63:0] req_input_value,
   input wire logic        req_input_valid,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_output_valid,
   input wire logic [63:0] rsp_output_value,
   input wire logic        rsp_input_taken,
   input wire logic [11:0] rsp_next_pc
);

   // clearing pass blocks transfers right after reset
   a_clear_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input accepted during memory clear");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_output_valid |-> rsp_output_value == 64'd0)
      else $error("output value without output");

   a_side_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_output_valid || rsp_input_taken) |->
      rsp_status == mdvc_pkg::STATUS_RUN && !(rsp_output_valid && rsp_input_taken))
      else $error("side effect reported with non-running status");

endmodule

bind mode_digit_virtual_cpu mdvc_checker u_mdvc_checker (.*);
`default_nettype wire
